// ===== rtl/core/a3d_pkg.sv =====
// Shared types and constants for the 3-bit adaptive delta audio decoder.
package a3d_pkg;

   localparam int GROUP_W         = 48;
   localparam int COUNT_W         = 5;
   localparam int CODE_W          = 3;
   localparam int LEVEL_W         = 14;
   localparam int PCM_W           = 16;
   localparam int CODES_PER_GROUP = 16;
   localparam int A3D_QUEUE_DEPTH = 2;

   // signed width of the difference / prediction datapath
   localparam int DP_W            = 20;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 14'h3fff;
   localparam logic [LEVEL_W-1:0] STEP_MIN  = 14'd2;
   localparam logic [LEVEL_W-1:0] STEP_MAX  = 14'h3fff;
   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(CODES_PER_GROUP);

   typedef enum logic {
      CMD_LOAD,
      CMD_DECODE
   } a3d_cmd_kind_type;

   typedef struct packed {
      a3d_cmd_kind_type     kind;
      logic [GROUP_W-1:0]   group;
      logic [COUNT_W-1:0]   count;
   } a3d_cmd_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_RUN
   } a3d_back_state_type;

endpackage

// ===== rtl/core/a3d_if.sv =====
// Valid/ready channel interfaces for the decoder's input groups and PCM results.
interface a3d_req_if import a3d_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                is_header;
   logic [GROUP_W-1:0]  group;
   logic [COUNT_W-1:0]  sample_count;

   modport source (output valid, is_header, group, sample_count, input ready);
   modport sink   (input valid, is_header, group, sample_count, output ready);
endinterface

interface a3d_rsp_if import a3d_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [PCM_W-1:0]  pcm_sample;
   logic                     last_in_group;

   modport source (output valid, pcm_sample, last_in_group, input ready);
   modport sink   (input valid, pcm_sample, last_in_group, output ready);
endinterface

// ===== rtl/core/adaptive_3bit_delta_audio_decoder.sv =====
// Top level of the 3-bit adaptive delta audio decoder.
//
// Usage:
//   req_chan carries one 48-bit group per beat plus is_header and sample_count.
//   A header beat loads step size, current and previous level; it gives no
//   result. A data beat decodes min(sample_count,16) codes, least significant
//   first; sample_count of zero is dropped with no result.
//   rsp_chan returns one signed 16-bit PCM beat per code; last_in_group marks
//   the final sample of a data group.
// Path: with the engine idle, the first sample of a data group goes from the
//   queue entry through the engine pop into BACK_RUN, then the decode into
//   the output register.
// Throughput: one code per cycle through the decode engine unless rsp_chan
//   stalls; no new command is popped until a data group's last code is
//   decoded. The per-code recurrence on level and step size sets the rate.
// Stalls: rsp_chan stall freezes code decoding; the command queue keeps taking
//   beats until it is full, then req_chan.ready drops.
// Reset (synchronous, active high): predictor state cleared to zero, queue
//   emptied, no result pending.
module adaptive_3bit_delta_audio_decoder import a3d_pkg::*; #(
   parameter int QUEUE_DEPTH = A3D_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   a3d_req_if.sink    req_chan,
   a3d_rsp_if.source  rsp_chan
);

   // front -> queue
   logic         push_valid;
   logic         push_ready;
   a3d_cmd_type  push_cmd;

   // queue -> decode engine
   logic         pop_valid;
   logic         pop_ready;
   a3d_cmd_type  pop_cmd;

   // classify header / data, saturate the count, drop empty groups
   a3d_front u_front (
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   // decouples input acceptance from the per-code decode loop
   a3d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   // predictor, step adaptation and PCM output register
   a3d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ===== rtl/core/a3d_front.sv =====
// Front end: classifies input beats into load / decode commands for the queue.
module a3d_front import a3d_pkg::*; (
   a3d_req_if.sink      req_chan,
   output logic         push_valid,
   input  logic         push_ready,
   output a3d_cmd_type  push_cmd
);

   logic drop;

   // data group with nothing to decode: swallow it
   assign drop = !req_chan.is_header && (req_chan.sample_count == '0);

   assign push_valid     = req_chan.valid && !drop;
   assign req_chan.ready = drop ? 1'b1 : push_ready;

   always_comb begin
      push_cmd.kind  = req_chan.is_header ? CMD_LOAD : CMD_DECODE;
      push_cmd.group = req_chan.group;
      push_cmd.count = (req_chan.sample_count > COUNT_MAX) ? COUNT_MAX
                                                           : req_chan.sample_count;
   end

endmodule

// ===== rtl/core/a3d_queue.sv =====
// Small command FIFO between the front end and the decode engine.
module a3d_queue import a3d_pkg::*; #(
   parameter int DEPTH = A3D_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  a3d_cmd_type  push_cmd,
   output logic         pop_valid,
   input  logic         pop_ready,
   output a3d_cmd_type  pop_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   a3d_cmd_type       entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push_fire, pop_fire;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef SYNTHESIS
   a_occupancy_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue occupancy beyond depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue empty but pointers differ");
`endif

endmodule

// ===== rtl/core/a3d_back.sv =====
// Decoder: predictor state, PCM output reg, one 3-bit code per unstalled cycle.
module a3d_back import a3d_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         pop_valid,
   output logic         pop_ready,
   input  a3d_cmd_type  pop_cmd,
   a3d_rsp_if.source    rsp_chan
);

   a3d_back_state_type     state_ff, state_in;
   logic [LEVEL_W-1:0]     step_ff, step_in;
   logic [LEVEL_W-1:0]     cur_ff, cur_in;
   logic [LEVEL_W-1:0]     prev_ff, prev_in;
   logic [GROUP_W-1:0]     grp_ff;
   logic [COUNT_W-1:0]     cnt_ff;
   logic                   rsp_valid_ff;
   logic [PCM_W-1:0]       pcm_ff;
   logic                   last_ff;

   logic                   out_free;
   logic                   decode_fire;
   logic                   start_decode;
   logic                   load_state;

   logic [CODE_W-1:0]      code;
   logic signed [DP_W-1:0] s_val, s_q, base, prod, raw, diff, pred;
   logic [2:0]             mult_sel;
   logic [LEVEL_W-1:0]     level_new;
   logic [LEVEL_W+1:0]     ns_wide;
   logic [LEVEL_W-1:0]     step_new;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // control
   always_comb begin
      state_in     = state_ff;
      pop_ready    = 1'b0;
      decode_fire  = 1'b0;
      start_decode = 1'b0;
      load_state   = 1'b0;
      unique case (state_ff)
         BACK_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               unique case (pop_cmd.kind)
                  CMD_LOAD:   load_state = 1'b1;
                  CMD_DECODE: begin
                     start_decode = 1'b1;
                     state_in     = BACK_RUN;
                  end
                  default:    load_state = 1'b0;
               endcase
            end
         end
         BACK_RUN: begin
            decode_fire = out_free;
            if (out_free && (cnt_ff == COUNT_W'(1))) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // step-scaled difference: (s&~3) +/- k*s' then floor divide by four
   assign code  = grp_ff[CODE_W-1:0];
   assign s_val = $signed({{(DP_W-LEVEL_W){1'b0}}, step_ff});
   assign s_q   = {s_val[DP_W-1:2], 2'b00};
   assign base  = code[2] ? {s_val[DP_W-1:1], 1'b0} : s_val;
   assign mult_sel = code[2] ? ({1'b0, code[1:0]} + 3'd1) : {1'b0, code[1:0]};

   always_comb begin
      case (mult_sel)
         3'd0:    prod = '0;
         3'd1:    prod = base <<< 1;
         3'd2:    prod = base <<< 2;
         3'd3:    prod = (base <<< 2) + (base <<< 1);
         3'd4:    prod = base <<< 3;
         default: prod = '0;
      endcase
   end

   always_comb begin
      raw  = code[2] ? (s_q - prod) : (s_q + prod);
      diff = (raw >>> 2) - $signed({{(DP_W-1){1'b0}},
                                    (code[2] & code[1] & step_ff[0])});
      pred = $signed({{(DP_W-LEVEL_W-1){1'b0}}, cur_ff, 1'b0})
           - $signed({{(DP_W-LEVEL_W){1'b0}}, prev_ff}) + diff;
      if (pred < 0) begin
         level_new = '0;
      end else if (pred > $signed({{(DP_W-LEVEL_W){1'b0}}, LEVEL_MAX})) begin
         level_new = LEVEL_MAX;
      end else begin
         level_new = pred[LEVEL_W-1:0];
      end
   end

   // step adaptation
   always_comb begin
      if (!code[1]) begin
         ns_wide = {2'b00, step_ff} + {5'd0, step_ff[LEVEL_W-1:3]}
                 - {4'd0, step_ff[LEVEL_W-1:2]};
      end else begin
         ns_wide = {2'b00, step_ff} + {4'd0, step_ff[LEVEL_W-1:2]}
                 + (code[0] ? {3'd0, step_ff[LEVEL_W-1:1]} : '0);
      end
      if (ns_wide < {2'b00, STEP_MIN}) begin
         step_new = STEP_MIN;
      end else if (ns_wide > {2'b00, STEP_MAX}) begin
         step_new = STEP_MAX;
      end else begin
         step_new = ns_wide[LEVEL_W-1:0];
      end
   end

   // predictor state
   always_comb begin
      step_in = step_ff;
      cur_in  = cur_ff;
      prev_in = prev_ff;
      if (load_state) begin
         step_in = pop_cmd.group[LEVEL_W-1:0];
         cur_in  = pop_cmd.group[2*LEVEL_W-1:LEVEL_W];
         prev_in = pop_cmd.group[3*LEVEL_W-1:2*LEVEL_W];
      end else if (decode_fire) begin
         step_in = step_new;
         cur_in  = level_new;
         prev_in = cur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         cur_ff  <= '0;
         prev_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         step_ff <= step_in;
         cur_ff  <= cur_in;
         prev_ff <= prev_in;
         if (start_decode) begin
            cnt_ff <= pop_cmd.count;
         end else if (decode_fire) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start_decode) begin
         grp_ff <= pop_cmd.group;
      end else if (decode_fire) begin
         grp_ff <= {{CODE_W{1'b0}}, grp_ff[GROUP_W-1:CODE_W]};
      end
   end

   // output register; level minus midscale is the level with its top bit flipped
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (decode_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (decode_fire) begin
         pcm_ff  <= {~level_new[LEVEL_W-1], level_new[LEVEL_W-2:0], 2'b00};
         last_ff <= (cnt_ff == COUNT_W'(1));
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.pcm_sample    = $signed(pcm_ff);
   assign rsp_chan.last_in_group = last_ff;

`ifndef SYNTHESIS
   a_run_has_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_RUN) |-> (cnt_ff != '0))
      else $error("decode running with no codes left");

   a_step_floor: assert property (@(posedge clock) disable iff (reset)
      decode_fire |=> (step_ff >= STEP_MIN))
      else $error("step size below minimum after decode");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (decode_fire && (cnt_ff == COUNT_W'(1))) |=> (state_ff == BACK_IDLE))
      else $error("engine still running after last code");
`endif

endmodule
